FILE: src/sba_pkg.sv
// Shared types, constants and helper functions of the sector bitmap allocator.
package sba_pkg;

    localparam int TRACK_SLOTS = 42;
    localparam int MAX_SECTORS = 21;
    localparam int DIR_TRACK   = 18;

    localparam int CMD_W   = 2;
    localparam int TRK_W   = 6;
    localparam int SEC_W   = 5;
    localparam int CNT_W   = 5;
    localparam int TOTAL_W = 10;
    localparam int ADDR_W  = $clog2(TRACK_SLOTS);

    localparam int DATA_W      = 32;
    localparam int PADDR_W     = 3;
    localparam int REG_IDX_LSB = 2;

    localparam logic [PADDR_W-REG_IDX_LSB-1:0] REG_TRACK_COUNT = '0;
    localparam logic [TRK_W-1:0] TRACK_COUNT_RST = TRK_W'(35);

    // Zone boundaries (last track of each zone) and the sectors per track in each zone.
    localparam int ZONE1_LAST    = 17;
    localparam int ZONE2_LAST    = 24;
    localparam int ZONE3_LAST    = 30;
    localparam int ZONE1_SECTORS = 21;
    localparam int ZONE2_SECTORS = 19;
    localparam int ZONE3_SECTORS = 18;
    localparam int ZONE4_SECTORS = 17;

    typedef enum logic [CMD_W-1:0] {
        CMD_QUERY   = 2'd0,
        CMD_ALLOC   = 2'd1,
        CMD_RELEASE = 2'd2
    } t_cmd;

    typedef enum logic [1:0] {
        STAT_OK      = 2'd0,
        STAT_INVALID = 2'd1,
        STAT_TAKEN   = 2'd2
    } t_status;

    typedef enum logic {
        SW_SWEEP = 1'b0,
        SW_RUN   = 1'b1
    } t_sweep_state;

    typedef logic [MAX_SECTORS-1:0] t_row;

    typedef struct packed {
        logic [CMD_W-1:0] command;
        logic [TRK_W-1:0] track;
        logic [SEC_W-1:0] sector;
    } t_in_item;

    typedef struct packed {
        t_status            status;
        logic               sector_free;
        logic [CNT_W-1:0]   track_free_count;
        logic [TOTAL_W-1:0] free_total;
    } t_out_item;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
    } t_map_rd_req;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        t_row              row;
    } t_map_wr;

    typedef struct packed {
        logic inc;
        logic dec;
    } t_total_upd;

    function automatic logic [CNT_W-1:0] sectors_on(input logic [TRK_W-1:0] trk);
        logic [CNT_W-1:0] n;
        if (trk <= TRK_W'(ZONE1_LAST)) begin
            n = CNT_W'(ZONE1_SECTORS);
        end else if (trk <= TRK_W'(ZONE2_LAST)) begin
            n = CNT_W'(ZONE2_SECTORS);
        end else if (trk <= TRK_W'(ZONE3_LAST)) begin
            n = CNT_W'(ZONE3_SECTORS);
        end else begin
            n = CNT_W'(ZONE4_SECTORS);
        end
        if (n > CNT_W'(MAX_SECTORS)) begin
            n = CNT_W'(MAX_SECTORS);
        end
        return n;
    endfunction

    function automatic t_row reset_row(input logic [TRK_W-1:0] trk);
        logic [CNT_W-1:0] n;
        t_row             row;
        n = sectors_on(trk);
        for (int i = 0; i < MAX_SECTORS; i++) begin
            row[i] = (CNT_W'(i) < n);
        end
        return row;
    endfunction

    function automatic logic [CNT_W-1:0] popcount(input t_row row);
        logic [CNT_W-1:0] c;
        c = '0;
        for (int i = 0; i < MAX_SECTORS; i++) begin
            c = c + CNT_W'(row[i]);
        end
        return c;
    endfunction

    function automatic logic [TRK_W-1:0] tracks_in_use(input logic [TRK_W-1:0] tc);
        return (tc > TRK_W'(TRACK_SLOTS)) ? TRK_W'(TRACK_SLOTS) : tc;
    endfunction

endpackage

FILE: src/sba_free_map.sv
// Free-sector bitmap memory with registered read, written-entry flags and write forwarding.
module sba_free_map import sba_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_map_rd_req i_rd,
    input  t_map_wr     i_wr,
    output t_row        o_row
);

    t_row              r_mem [TRACK_SLOTS];
    logic [TRACK_SLOTS-1:0] r_written;
    t_row              r_rd_row;
    t_row              r_fwd_row;
    logic              r_vld;
    logic              r_fwd;
    logic [ADDR_W-1:0] r_addr;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.row;
        end
        if (i_rd.en) begin
            r_rd_row  <= r_mem[i_rd.addr];
            r_addr    <= i_rd.addr;
            r_vld     <= r_written[i_rd.addr];
            // When the same entry is written at this edge, the written row is forwarded in place of the old one.
            r_fwd     <= i_wr.en && (i_wr.addr == i_rd.addr);
            r_fwd_row <= i_wr.row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_written <= '0;
        end else if (i_wr.en) begin
            r_written[i_wr.addr] <= 1'b1;
        end
    end

    // An entry never written still holds its reset pattern: every sector of the track free.
    always_comb begin
        if (r_fwd) begin
            o_row = r_fwd_row;
        end else if (r_vld) begin
            o_row = r_rd_row;
        end else begin
            o_row = reset_row(TRK_W'(r_addr) + TRK_W'(1));
        end
    end

endmodule

FILE: src/sba_update.sv
// Per-request bitmap update: status, new row, sector and track free state.
module sba_update import sba_pkg::*; (
    input  logic               i_item,
    input  logic [CMD_W-1:0]   i_cmd,
    input  logic [TRK_W-1:0]   i_trk,
    input  logic [SEC_W-1:0]   i_sec,
    input  logic               i_addr_ok,
    input  t_row               i_row,
    output t_map_wr            o_wr,
    output t_total_upd         o_upd,
    output t_status            o_status,
    output logic               o_sector_free,
    output logic [CNT_W-1:0]   o_track_free_count
);

    t_row bit_sel;
    t_row new_row;
    logic is_free;
    logic do_alloc;
    logic do_rel;
    logic not_dir;

    always_comb begin
        bit_sel  = t_row'(1) << i_sec;
        is_free  = |(i_row & bit_sel);
        do_alloc = i_item && i_addr_ok && (i_cmd == CMD_ALLOC) && is_free;
        do_rel   = i_item && i_addr_ok && (i_cmd == CMD_RELEASE) && !is_free;
        not_dir  = (i_trk != TRK_W'(DIR_TRACK));

        new_row = i_row;
        if (do_alloc) begin
            new_row = i_row & ~bit_sel;
        end else if (do_rel) begin
            new_row = i_row | bit_sel;
        end

        if (!i_addr_ok) begin
            o_status = STAT_INVALID;
        end else if ((i_cmd == CMD_ALLOC) && !is_free) begin
            o_status = STAT_TAKEN;
        end else begin
            o_status = STAT_OK;
        end

        o_sector_free      = i_addr_ok && |(new_row & bit_sel);
        o_track_free_count = i_addr_ok ? popcount(new_row) : '0;

        o_wr.en   = do_alloc || do_rel;
        o_wr.addr = ADDR_W'(i_trk - TRK_W'(1));
        o_wr.row  = new_row;

        // The directory track never counts toward the disk total.
        o_upd.inc = do_rel && not_dir;
        o_upd.dec = do_alloc && not_dir;
    end

endmodule

FILE: src/sba_total.sv
// Disk free total register and the rebuild sweep that recomputes it from the bitmap.
module sba_total import sba_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_wr,
    input  logic [TRK_W-1:0]   i_tracks,
    input  t_row               i_row,
    input  t_total_upd         i_upd,
    output t_map_rd_req        o_rd,
    output logic               o_busy,
    output logic [TOTAL_W-1:0] o_total_next
);

    t_sweep_state       r_state;
    t_sweep_state       n_state;
    logic [ADDR_W-1:0]  r_cnt;
    logic [ADDR_W-1:0]  n_cnt;
    logic               r_pend;
    logic [TRK_W-1:0]   r_pend_trk;
    logic [TOTAL_W-1:0] r_total;
    logic [TOTAL_W-1:0] n_total;
    logic               sweeping;
    logic               add_row;

    always_comb begin
        n_state = r_state;
        case (r_state)
            SW_SWEEP: begin
                if (r_cnt == ADDR_W'(TRACK_SLOTS - 1)) begin
                    n_state = SW_RUN;
                end
            end
            SW_RUN: begin
                n_state = SW_RUN;
            end
            default: begin
                n_state = SW_SWEEP;
            end
        endcase
        // A new track count restarts the rebuild from the first track.
        if (i_cfg_wr) begin
            n_state = SW_SWEEP;
        end
    end

    always_comb begin
        sweeping  = (r_state == SW_SWEEP);
        o_rd.en   = sweeping;
        o_rd.addr = r_cnt;
        o_busy    = sweeping || r_pend;
    end

    always_comb begin
        n_cnt   = (sweeping && !i_cfg_wr) ? r_cnt + ADDR_W'(1) : '0;
        add_row = r_pend && (r_pend_trk <= i_tracks) && (r_pend_trk != TRK_W'(DIR_TRACK));
        if (i_cfg_wr) begin
            n_total = '0;
        end else if (add_row) begin
            n_total = r_total + TOTAL_W'(popcount(i_row));
        end else if (i_upd.inc) begin
            n_total = r_total + TOTAL_W'(1);
        end else if (i_upd.dec) begin
            n_total = r_total - TOTAL_W'(1);
        end else begin
            n_total = r_total;
        end
        o_total_next = n_total;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= SW_SWEEP;
            r_cnt   <= '0;
            r_pend  <= 1'b0;
            r_total <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_pend  <= sweeping && !i_cfg_wr;
            r_total <= n_total;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pend_trk <= TRK_W'(r_cnt) + TRK_W'(1);
    end

endmodule

FILE: src/sector_bitmap_allocator.sv
// Sector bitmap allocator top level: command port, register port and request pipeline.
//
// Each request (query, allocate or release of one track and sector) passes from its transfer at
// start through the request and result registers to its one-cycle o_valid strobe, and a new
// request is taken every cycle unless busy is high. The bitmap lives in a 42-entry memory with
// a registered read; a write of the previous request to the same track is forwarded into the
// read. The receiver cannot stall, so every result must be taken in the cycle that o_valid is
// high. After reset and after every write of track_count, busy stays high while a sweep reads
// all 42 tracks and rebuilds the disk free total; register writes are still taken during it.
module sector_bitmap_allocator import sba_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  t_in_item           i_item,
    output logic               o_valid,
    output t_out_item          o_result,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0]  pwdata,
    output logic [DATA_W-1:0]  prdata,
    output logic               pready
);

    logic [TRK_W-1:0] r_track_count;
    logic [TRK_W-1:0] tracks_eff;
    logic             reg_sel;
    logic             cfg_wr;
    logic             accept;
    logic             addr_ok;
    logic             sweep_busy;
    t_map_rd_req      sweep_rd;
    t_map_rd_req      map_rd;
    t_map_wr          map_wr;
    t_row             map_row;
    t_total_upd       total_upd;
    logic [TOTAL_W-1:0] total_next;

    logic             r_b_item;
    logic [CMD_W-1:0] r_b_cmd;
    logic [TRK_W-1:0] r_b_trk;
    logic [SEC_W-1:0] r_b_sec;
    logic             r_b_ok;

    t_status          upd_status;
    logic             upd_sector_free;
    logic [CNT_W-1:0] upd_count;

    logic             r_out_valid;
    t_out_item        r_out;

    // Register port
    assign reg_sel = (paddr[PADDR_W-1:REG_IDX_LSB] == REG_TRACK_COUNT);
    assign cfg_wr  = psel && penable && pwrite && pready && reg_sel;
    assign pready  = 1'b1;
    assign prdata  = reg_sel ? {{(DATA_W-TRK_W){1'b0}}, r_track_count} : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_track_count <= TRACK_COUNT_RST;
        end else if (cfg_wr) begin
            r_track_count <= pwdata[TRK_W-1:0];
        end
    end

    assign tracks_eff = tracks_in_use(r_track_count);

    // Request transfer and address check
    assign busy   = !i_rst_n || sweep_busy;
    assign accept = start && !busy;

    always_comb begin
        addr_ok = (i_item.track != '0) && (i_item.track <= tracks_eff) &&
                  (i_item.sector < sectors_on(i_item.track));
        if (accept) begin
            map_rd.en   = 1'b1;
            map_rd.addr = addr_ok ? ADDR_W'(i_item.track - TRK_W'(1)) : '0;
        end else begin
            map_rd = sweep_rd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_item <= 1'b0;
        end else begin
            r_b_item <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_b_cmd <= i_item.command;
            r_b_trk <= i_item.track;
            r_b_sec <= i_item.sector;
            r_b_ok  <= addr_ok;
        end
    end

    sba_free_map u_map (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rd    (map_rd),
        .i_wr    (map_wr),
        .o_row   (map_row)
    );

    sba_update u_update (
        .i_item             (r_b_item),
        .i_cmd              (r_b_cmd),
        .i_trk              (r_b_trk),
        .i_sec              (r_b_sec),
        .i_addr_ok          (r_b_ok),
        .i_row              (map_row),
        .o_wr               (map_wr),
        .o_upd              (total_upd),
        .o_status           (upd_status),
        .o_sector_free      (upd_sector_free),
        .o_track_free_count (upd_count)
    );

    sba_total u_total (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_wr     (cfg_wr),
        .i_tracks     (tracks_eff),
        .i_row        (map_row),
        .i_upd        (total_upd),
        .o_rd         (sweep_rd),
        .o_busy       (sweep_busy),
        .o_total_next (total_next)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= r_b_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_b_item) begin
            r_out.status           <= upd_status;
            r_out.sector_free      <= upd_sector_free;
            r_out.track_free_count <= upd_count;
            r_out.free_total       <= total_next;
        end
    end

    assign o_valid  = r_out_valid;
    assign o_result = r_out;

endmodule

FILE: src/sba_checker.sv
// Port-level assertions for the sector bitmap allocator and the bind that attaches them.
module sba_checker import sba_pkg::*; (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      start,
    input logic      busy,
    input logic      o_valid,
    input t_out_item o_result
);

    // Every transfer yields exactly one result.
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##2 o_valid)
        else $error("request transfer without a result two cycles later");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(start && !busy) |-> ##2 !o_valid)
        else $error("result strobe without a matching request");

    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_result.status == STAT_INVALID)) |->
            (!o_result.sector_free && (o_result.track_free_count == '0)))
        else $error("invalid address reported nonzero sector or track state");

    a_taken_not_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_result.status == STAT_TAKEN)) |-> !o_result.sector_free)
        else $error("allocate of taken sector reported the sector free");

    a_free_counted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_result.sector_free) |-> (o_result.track_free_count != '0))
        else $error("free sector on a track with a zero free count");

endmodule

bind sector_bitmap_allocator sba_checker u_sba_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .o_valid  (o_valid),
    .o_result (o_result)
);
